>>> hw/rtl/ddmt_pkg.sv
// Shared types and constants for the domain device mask table.
// Opcodes, result status codes, controller states and the control/status structs.
// No dependencies.
package ddmt_pkg;

   localparam int DOM_W  = 16;
   localparam int PID_W  = 16;
   localparam int MASK_W = 32;
   localparam int STAT_W = 3;
   localparam int OP_W   = 2;
   localparam int SLOT_W = 5;
   localparam int ROWF_W = 4;
   localparam int CFG_W  = 5;
   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(16);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_ASSIGN  = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_PENDING  = 3'd0,
      STAT_DONE     = 3'd1,
      STAT_NODEV    = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NOTFOUND = 3'd4,
      STAT_LOADED   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_PICK,
      S_READ,
      S_CMP,
      S_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;          // capture request fields
      logic capture_match;  // register slot compare vector
      logic update_pending; // merge matched slot into pending mask
      logic scan_start;     // clear scan state
      logic scan_read;      // read table row at scan index
      logic scan_cmp;       // evaluate read row, advance index
      logic commit;         // apply update, load response register
   } ddmt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_request;     // latched opcode is assign or release
      logic last;
      logic rows_zero;      // no rows searched
      logic hit;            // row under compare holds the domain
      logic scan_end;       // row under compare is the last searched one
      logic out_free;       // response register can take a result
   } ddmt_stat_type;

endpackage

>>> hw/rtl/ddmt_ctrl.sv
// Sequencer for the domain device mask table.
// Depends on ddmt_pkg for state, command and status types.
module ddmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ddmt_pkg::ddmt_stat_type stat,
   output ddmt_pkg::ddmt_cmd_type  cmd
);
   import ddmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.capture_match = 1'b1;
            state_in = stat.is_request ? S_PICK : S_FINISH;
         end
         S_PICK: begin
            cmd.update_pending = 1'b1;
            if (!stat.last) begin
               state_in = S_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = stat.rows_zero ? S_FINISH : S_READ;
            end
         end
         S_READ: begin
            cmd.scan_read = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in = (stat.hit || stat.scan_end) ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/ddmt_datapath.sv
// Datapath: device map, domain table memory, pending mask, scan and response register.
// Depends on ddmt_pkg for widths, codes and command/status structs.
module ddmt_datapath #(
   parameter int TABLE_ROWS   = 16,
   parameter int DEVICE_SLOTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ddmt_pkg::ddmt_cmd_type               cmd,
   output ddmt_pkg::ddmt_stat_type              stat,
   input  logic                                 csr_wen,
   input  logic [ddmt_pkg::CFG_W-1:0]           csr_wdata,
   input  logic [ddmt_pkg::OP_W-1:0]            req_opcode,
   input  logic [ddmt_pkg::DOM_W-1:0]           req_domain_id,
   input  logic [ddmt_pkg::PID_W-1:0]           req_pci_id,
   input  logic [ddmt_pkg::SLOT_W-1:0]          req_device_slot,
   input  logic                                 req_slot_present,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ddmt_pkg::STAT_W-1:0]          rsp_status,
   output logic                                 rsp_unknown_device,
   output logic [ddmt_pkg::ROWF_W-1:0]          rsp_row,
   output logic [ddmt_pkg::MASK_W-1:0]          rsp_old_mask,
   output logic [ddmt_pkg::MASK_W-1:0]          rsp_new_mask
);
   import ddmt_pkg::*;

   localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
   localparam int NW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int SIDX_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
   localparam int ENT_W  = DOM_W + MASK_W;

   // latched request
   logic [OP_W-1:0]   op_ff;
   logic [DOM_W-1:0]  dom_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              present_ff;
   logic              last_ff;

   // device map
   logic [PID_W-1:0]        slot_pid_ff [DEVICE_SLOTS];
   logic [DEVICE_SLOTS-1:0] slot_valid_ff;
   logic [DEVICE_SLOTS-1:0] match_in;
   logic [DEVICE_SLOTS-1:0] match_ff;
   logic [DEVICE_SLOTS-1:0] match_low;

   logic [MASK_W-1:0] pending_ff;
   logic              unknown_ff;
   logic [CFG_W-1:0]  rows_ff;

   // domain table: {domain, mask} per row
   logic [ENT_W-1:0]      entry_mem [TABLE_ROWS];
   logic [ENT_W-1:0]      rd_data_ff;
   logic [TABLE_ROWS-1:0] entry_valid_ff;

   // scan state
   logic [NW-1:0]     idx_ff;
   logic [NW-1:0]     rows_lim;
   logic [ROW_W-1:0]  idx_row;
   logic              found_ff;
   logic [ROW_W-1:0]  sel_ff;
   logic [MASK_W-1:0] oldm_ff;
   logic              free_ff;
   logic [ROW_W-1:0]  vacant_row_ff;
   logic              hit;

   // commit decision
   logic [STAT_W-1:0] res_status;
   logic              res_unknown;
   logic [ROW_W-1:0]  res_row;
   logic [MASK_W-1:0] res_old;
   logic [MASK_W-1:0] res_new;
   logic              wr_en;
   logic              claim;
   logic              clear_pending;
   logic              slot_in_range;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_unknown_ff;
   logic [ROWF_W-1:0] rsp_row_ff;
   logic [MASK_W-1:0] rsp_old_ff;
   logic [MASK_W-1:0] rsp_new_ff;

   assign rows_lim = (NW'(rows_ff) > NW'(TABLE_ROWS)) ? NW'(TABLE_ROWS) : NW'(rows_ff);
   assign idx_row  = idx_ff[ROW_W-1:0];
   assign hit      = entry_valid_ff[idx_row] && (rd_data_ff[ENT_W-1:MASK_W] == dom_ff);
   assign slot_in_range = ({1'b0, slot_ff} < (SLOT_W+1)'(DEVICE_SLOTS));

   always_comb begin
      for (int r = 0; r < DEVICE_SLOTS; r++) begin
         match_in[r] = slot_valid_ff[r] && (slot_pid_ff[r] == pid_ff);
      end
   end

   // lowest matching slot wins
   assign match_low = match_ff & (~match_ff + DEVICE_SLOTS'(1));

   assign stat.is_request = (op_ff == OP_ASSIGN) || (op_ff == OP_RELEASE);
   assign stat.last       = last_ff;
   assign stat.rows_zero  = (rows_lim == '0);
   assign stat.hit        = hit;
   assign stat.scan_end   = ((idx_ff + NW'(1)) == rows_lim);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      res_status    = STAT_PENDING;
      res_unknown   = 1'b0;
      res_row       = '0;
      res_old       = '0;
      res_new       = '0;
      wr_en         = 1'b0;
      claim         = 1'b0;
      clear_pending = 1'b0;
      case (op_ff)
         OP_LOAD: begin
            res_status = STAT_LOADED;
         end
         OP_ASSIGN: begin
            res_unknown = unknown_ff;
            if (last_ff) begin
               clear_pending = 1'b1;
               if (pending_ff == '0) begin
                  res_status = STAT_NODEV;
               end else if (found_ff) begin
                  res_status = STAT_DONE;
                  res_row    = sel_ff;
                  res_old    = oldm_ff;
                  res_new    = oldm_ff | pending_ff;
                  wr_en      = 1'b1;
               end else if (free_ff) begin
                  res_status = STAT_DONE;
                  res_row    = vacant_row_ff;
                  res_new    = pending_ff;
                  wr_en      = 1'b1;
                  claim      = 1'b1;
               end else begin
                  res_status = STAT_FULL;
               end
            end
         end
         OP_RELEASE: begin
            res_unknown = unknown_ff;
            if (last_ff) begin
               clear_pending = 1'b1;
               if (found_ff) begin
                  res_status = STAT_DONE;
                  res_row    = sel_ff;
                  res_old    = oldm_ff;
                  // empty release wipes the whole mask
                  res_new    = (pending_ff != '0) ? (oldm_ff & ~pending_ff) : '0;
                  wr_en      = 1'b1;
               end else begin
                  res_status = STAT_NOTFOUND;
               end
            end
         end
         default: begin
            res_status = STAT_PENDING;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_opcode;
         dom_ff     <= req_domain_id;
         pid_ff     <= req_pci_id;
         slot_ff    <= req_device_slot;
         present_ff <= req_slot_present;
         last_ff    <= req_last;
      end
      if (cmd.capture_match) begin
         match_ff <= match_in;
      end
      if (cmd.update_pending) begin
         unknown_ff <= ~|match_ff;
      end
      if (cmd.commit && (op_ff == OP_LOAD) && slot_in_range) begin
         slot_pid_ff[slot_ff[SIDX_W-1:0]] <= pid_ff;
      end
      if (cmd.scan_start) begin
         idx_ff <= '0;
      end else if (cmd.scan_cmp) begin
         idx_ff <= idx_ff + NW'(1);
      end
      if (cmd.scan_cmp) begin
         if (hit) begin
            sel_ff  <= idx_row;
            oldm_ff <= rd_data_ff[MASK_W-1:0];
         end else if (!entry_valid_ff[idx_row] && !free_ff) begin
            vacant_row_ff <= idx_row;
         end
      end
      if (cmd.commit) begin
         rsp_status_ff  <= res_status;
         rsp_unknown_ff <= res_unknown;
         rsp_row_ff     <= ROWF_W'(res_row);
         rsp_old_ff     <= res_old;
         rsp_new_ff     <= res_new;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         entry_mem[res_row] <= {dom_ff, res_new};
      end
      if (cmd.scan_read) begin
         rd_data_ff <= entry_mem[idx_row];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff  <= '0;
         entry_valid_ff <= '0;
         pending_ff     <= '0;
         rows_ff        <= ROWS_RESET;
         found_ff       <= 1'b0;
         free_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            rows_ff <= csr_wdata;
         end
         if (cmd.commit && (op_ff == OP_LOAD) && slot_in_range) begin
            slot_valid_ff[slot_ff[SIDX_W-1:0]] <= present_ff;
         end
         if (cmd.update_pending) begin
            pending_ff <= pending_ff | MASK_W'(match_low);
         end else if (cmd.commit && clear_pending) begin
            pending_ff <= '0;
         end
         if (cmd.commit && claim) begin
            entry_valid_ff[res_row] <= 1'b1;
         end
         if (cmd.scan_start) begin
            found_ff <= 1'b0;
            free_ff  <= 1'b0;
         end else if (cmd.scan_cmp) begin
            if (hit) begin
               found_ff <= 1'b1;
            end else if (!entry_valid_ff[idx_row]) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_unknown_device = rsp_unknown_ff;
   assign rsp_row            = rsp_row_ff;
   assign rsp_old_mask       = rsp_old_ff;
   assign rsp_new_mask       = rsp_new_ff;

endmodule

>>> hw/rtl/domain_device_mask_table.sv
// Domain device mask table: keeps a PCI id per device slot and a table of domain
// entries (domain id + device mask). Load items write a slot; assign and release
// items each carry one PCI id whose slot bit collects in a pending mask, and the
// item marked last applies that mask to the domain's entry. Every item gives
// exactly one result. A load or unused-opcode item passes from accept through the
// slot match state to the result; assign and release items also pass the pick
// state, and a last one then scans rows 0 to min(rows_in_use, TABLE_ROWS)-1, one
// registered read of the table memory and one compare per row, until a hit or the
// last row. The next request is taken in the cycle after the result is written
// to the response register, and it may enter while that result still waits; a
// result only waits in S_FINISH if the previous one was not yet taken.
// rows_in_use (csr_wdata, reset 16) sets how many rows the search covers.
// Depends on ddmt_pkg, ddmt_ctrl and ddmt_datapath.
module domain_device_mask_table #(
   parameter int TABLE_ROWS   = 16,
   parameter int DEVICE_SLOTS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration: rows_in_use
   input  logic                          csr_wen,
   input  logic [ddmt_pkg::CFG_W-1:0]    csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ddmt_pkg::OP_W-1:0]     req_opcode,
   input  logic [ddmt_pkg::DOM_W-1:0]    req_domain_id,
   input  logic [ddmt_pkg::PID_W-1:0]    req_pci_id,
   input  logic [ddmt_pkg::SLOT_W-1:0]   req_device_slot,
   input  logic                          req_slot_present,
   input  logic                          req_last,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ddmt_pkg::STAT_W-1:0]   rsp_status,
   output logic                          rsp_unknown_device,
   output logic [ddmt_pkg::ROWF_W-1:0]   rsp_row,
   output logic [ddmt_pkg::MASK_W-1:0]   rsp_old_mask,
   output logic [ddmt_pkg::MASK_W-1:0]   rsp_new_mask
);
   import ddmt_pkg::*;

   ddmt_cmd_type  cmd;
   ddmt_stat_type stat;

   // sequencer: one request in flight, transfer into response register at commit
   ddmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, slot match, row scan and response register
   ddmt_datapath #(
      .TABLE_ROWS   (TABLE_ROWS),
      .DEVICE_SLOTS (DEVICE_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_opcode),
      .req_domain_id      (req_domain_id),
      .req_pci_id         (req_pci_id),
      .req_device_slot    (req_device_slot),
      .req_slot_present   (req_slot_present),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_unknown_device (rsp_unknown_device),
      .rsp_row            (rsp_row),
      .rsp_old_mask       (rsp_old_mask),
      .rsp_new_mask       (rsp_new_mask)
   );

endmodule
